/* rtl/dactm_pkg.sv */
`default_nettype none

package dactm_pkg;

    // command codes carried in the mode field
    typedef enum logic [1:0] {
        MODE_PREPARE = 2'd0,
        MODE_START   = 2'd1,
        MODE_STOP    = 2'd2,
        MODE_TICK    = 2'd3
    } mode_t;

    // reply codes
    typedef enum logic [2:0] {
        REPLY_NONE     = 3'd0,
        REPLY_PREPARED = 3'd1,
        REPLY_MOVING   = 3'd2,
        REPLY_DONE     = 3'd3,
        REPLY_STOPPED  = 3'd4
    } reply_t;

    localparam logic [15:0] TIMEOUT_RESET = 16'd10000;

    // per-channel bridge control for one word
    typedef struct packed {
        logic drive;    // armed start: set pins from stored direction
        logic coast;    // stop: both bridge pins low
        logic tick;     // tick during a move: coast once duration reached
    } chan_ctrl_t;

endpackage

`default_nettype wire

/* rtl/dactm_if.sv */
`default_nettype none

// command channel
interface dactm_cmd_if;
    logic              valid;
    logic              ready;
    logic [1:0]        mode;
    logic signed [1:0] dir_a;
    logic [15:0]       time_a;
    logic signed [1:0] dir_b;
    logic [15:0]       time_b;

    modport source (output valid, mode, dir_a, time_a, dir_b, time_b, input ready);
    modport sink   (input valid, mode, dir_a, time_a, dir_b, time_b, output ready);
endinterface

// result channel
interface dactm_res_if;
    logic       valid;
    logic       ready;
    logic [2:0] reply;
    logic       fwd_a;
    logic       rev_a;
    logic       awake_a;
    logic       fwd_b;
    logic       rev_b;
    logic       awake_b;

    modport source (output valid, reply, fwd_a, rev_a, awake_a, fwd_b, rev_b, awake_b,
                    input ready);
    modport sink   (input valid, reply, fwd_a, rev_a, awake_a, fwd_b, rev_b, awake_b,
                    output ready);
endinterface

`default_nettype wire

/* rtl/dactm_chan.sv */
`default_nettype none

module dactm_chan
    import dactm_pkg::*;
#(
    parameter int TIME_BITS = 16
)
(
    input  wire chan_ctrl_t           ctrl,
    input  wire logic [1:0]           dir,
    input  wire logic [TIME_BITS-1:0] dur,
    input  wire logic [TIME_BITS:0]   elapsed_next,
    input  wire logic                 fwd_cur,
    input  wire logic                 rev_cur,
    output logic                      fwd_next,
    output logic                      rev_next,
    output logic                      finished
);

    logic untimed;
    logic reached;

    assign untimed  = (dur == '0);
    assign reached  = (elapsed_next >= {1'b0, dur});
    assign finished = untimed || reached;

    always_comb
    begin
        fwd_next = fwd_cur;
        rev_next = rev_cur;
        if (ctrl.drive)
        begin
            // negative codes, including minus two, mean retract
            fwd_next = (dir == 2'b01);
            rev_next = dir[1];
        end
        else if (ctrl.coast || (ctrl.tick && !untimed && reached))
        begin
            fwd_next = 1'b0;
            rev_next = 1'b0;
        end
    end

endmodule

`default_nettype wire

/* rtl/dual_actuator_timed_move.sv */
// a result word is registered and appears in the cycle after its command word is taken
// throughput: one command word per cycle while the result channel is not stalled; the state
//   update and the result register are written on the same edge, so nothing waits on a loop
// reset (rst_n low, asynchronous): disarmed, not moving, elapsed count and
//   stored moves zero, all bridge pins low, drivers asleep, timeout 10000
`default_nettype none

module dual_actuator_timed_move
    import dactm_pkg::*;
#(
    parameter int TIME_BITS = 16
)
(
    input  wire logic        clk,
    input  wire logic        rst_n,
    input  wire logic        cfg_wr_en,
    input  wire logic [15:0] cfg_wr_data,
    dactm_cmd_if.sink        cmd,
    dactm_res_if.source      res
);

    // compare width covering both the elapsed count and the timeout
    localparam int CMP_W = (TIME_BITS + 1 > 16) ? TIME_BITS + 1 : 16;

    // configuration
    logic [15:0] timeout_reg;

    // move state
    logic                 armed_reg,   armed_next;
    logic                 moving_reg,  moving_next;
    logic [TIME_BITS:0]   elapsed_reg, elapsed_next;
    logic [1:0]           dir_a_reg,   dir_a_next;
    logic [1:0]           dir_b_reg,   dir_b_next;
    logic [TIME_BITS-1:0] dur_a_reg,   dur_a_next;
    logic [TIME_BITS-1:0] dur_b_reg,   dur_b_next;

    // pin levels; both drivers always share one sleep level
    logic fwd_a_reg, fwd_a_next;
    logic rev_a_reg, rev_a_next;
    logic fwd_b_reg, fwd_b_next;
    logic rev_b_reg, rev_b_next;
    logic awake_reg, awake_next;

    // result register
    logic   res_valid_reg;
    reply_t reply_reg, reply_next;

    logic accept;
    mode_t mode;

    // durations fitted to the stored width
    logic [TIME_BITS+15:0] time_a_ext;
    logic [TIME_BITS+15:0] time_b_ext;
    logic [TIME_BITS-1:0]  time_a_fit;
    logic [TIME_BITS-1:0]  time_b_fit;

    // elapsed count and timeout test
    logic [TIME_BITS:0]   elapsed_inc;
    logic [CMP_W-1:0]     elapsed_cmp;
    logic [CMP_W-1:0]     timeout_cmp;
    logic [CMP_W+15:0]    elapsed_ext;
    logic [CMP_W+15:0]    timeout_ext;
    logic                 timed_out;

    chan_ctrl_t ctrl;
    logic       fin_a, fin_b;

    // output stage frees up when empty or being drained
    assign cmd.ready = !res_valid_reg || res.ready;
    assign accept    = cmd.valid && cmd.ready;
    assign mode      = mode_t'(cmd.mode);

    assign time_a_ext = {{TIME_BITS{1'b0}}, cmd.time_a};
    assign time_b_ext = {{TIME_BITS{1'b0}}, cmd.time_b};
    assign time_a_fit = time_a_ext[TIME_BITS-1:0];
    assign time_b_fit = time_b_ext[TIME_BITS-1:0];

    // saturating increment of the elapsed count
    assign elapsed_inc = (&elapsed_reg) ? elapsed_reg : elapsed_reg + 1'b1;

    assign elapsed_ext = {{(CMP_W + 15 - TIME_BITS){1'b0}}, elapsed_inc};
    assign timeout_ext = {{CMP_W{1'b0}}, timeout_reg};
    assign elapsed_cmp = elapsed_ext[CMP_W-1:0];
    assign timeout_cmp = timeout_ext[CMP_W-1:0];
    assign timed_out   = (elapsed_cmp > timeout_cmp);

    // bridge control shared by both channels
    always_comb
    begin
        ctrl.drive = 1'b0;
        ctrl.coast = 1'b0;
        ctrl.tick  = 1'b0;
        case (mode)
            MODE_START: ctrl.drive = armed_reg;
            MODE_STOP:  ctrl.coast = 1'b1;
            MODE_TICK:  ctrl.tick  = moving_reg;
            default:    ctrl.drive = 1'b0;
        endcase
    end

    dactm_chan #(
        .TIME_BITS    (TIME_BITS)
    ) u_chan_a (
        .ctrl         (ctrl),
        .dir          (dir_a_reg),
        .dur          (dur_a_reg),
        .elapsed_next (elapsed_inc),
        .fwd_cur      (fwd_a_reg),
        .rev_cur      (rev_a_reg),
        .fwd_next     (fwd_a_next),
        .rev_next     (rev_a_next),
        .finished     (fin_a)
    );

    dactm_chan #(
        .TIME_BITS    (TIME_BITS)
    ) u_chan_b (
        .ctrl         (ctrl),
        .dir          (dir_b_reg),
        .dur          (dur_b_reg),
        .elapsed_next (elapsed_inc),
        .fwd_cur      (fwd_b_reg),
        .rev_cur      (rev_b_reg),
        .fwd_next     (fwd_b_next),
        .rev_next     (rev_b_next),
        .finished     (fin_b)
    );

    // flags, count, stored move and reply for the accepted word
    always_comb
    begin
        armed_next   = armed_reg;
        moving_next  = moving_reg;
        elapsed_next = elapsed_reg;
        dir_a_next   = dir_a_reg;
        dir_b_next   = dir_b_reg;
        dur_a_next   = dur_a_reg;
        dur_b_next   = dur_b_reg;
        awake_next   = awake_reg;
        reply_next   = REPLY_NONE;
        case (mode)
            MODE_PREPARE:
            begin
                // a running move carries on with the new durations
                dir_a_next = cmd.dir_a;
                dir_b_next = cmd.dir_b;
                dur_a_next = time_a_fit;
                dur_b_next = time_b_fit;
                armed_next = 1'b1;
                reply_next = REPLY_PREPARED;
            end
            MODE_START:
            begin
                if (armed_reg)
                begin
                    if ((dur_a_reg == '0) && (dur_b_reg == '0))
                    begin
                        // instant move: pins set, drivers straight back to sleep
                        awake_next = 1'b0;
                        reply_next = REPLY_DONE;
                    end
                    else
                    begin
                        awake_next   = 1'b1;
                        elapsed_next = '0;
                        moving_next  = 1'b1;
                        reply_next   = REPLY_MOVING;
                    end
                end
            end
            MODE_STOP:
            begin
                awake_next  = 1'b0;
                moving_next = 1'b0;
                armed_next  = 1'b0;
                reply_next  = REPLY_STOPPED;
            end
            MODE_TICK:
            begin
                if (moving_reg)
                begin
                    elapsed_next = elapsed_inc;
                    // end of move sleeps the drivers; pins coast only on timed channels that reached their time
                    if ((fin_a && fin_b) || timed_out)
                    begin
                        moving_next = 1'b0;
                        armed_next  = 1'b0;
                        awake_next  = 1'b0;
                        reply_next  = REPLY_DONE;
                    end
                end
            end
            default:
            begin
                reply_next = REPLY_NONE;
            end
        endcase
    end

    // configuration register
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            timeout_reg <= TIMEOUT_RESET;
        end
        else if (cfg_wr_en)
        begin
            timeout_reg <= cfg_wr_data;
        end
    end

    // move state, updated on every accepted word
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            armed_reg   <= 1'b0;
            moving_reg  <= 1'b0;
            elapsed_reg <= '0;
            dir_a_reg   <= '0;
            dir_b_reg   <= '0;
            dur_a_reg   <= '0;
            dur_b_reg   <= '0;
            fwd_a_reg   <= 1'b0;
            rev_a_reg   <= 1'b0;
            fwd_b_reg   <= 1'b0;
            rev_b_reg   <= 1'b0;
            awake_reg   <= 1'b0;
        end
        else if (accept)
        begin
            armed_reg   <= armed_next;
            moving_reg  <= moving_next;
            elapsed_reg <= elapsed_next;
            dir_a_reg   <= dir_a_next;
            dir_b_reg   <= dir_b_next;
            dur_a_reg   <= dur_a_next;
            dur_b_reg   <= dur_b_next;
            fwd_a_reg   <= fwd_a_next;
            rev_a_reg   <= rev_a_next;
            fwd_b_reg   <= fwd_b_next;
            rev_b_reg   <= rev_b_next;
            awake_reg   <= awake_next;
        end
    end

    // result valid flag
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            res_valid_reg <= 1'b0;
        end
        else if (cmd.ready)
        begin
            res_valid_reg <= accept;
        end
    end

    // result payload: reply plus the pin levels after the word
    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            reply_reg <= reply_next;
        end
    end

    assign res.valid   = res_valid_reg;
    assign res.reply   = reply_reg;
    assign res.fwd_a   = fwd_a_reg;
    assign res.rev_a   = rev_a_reg;
    assign res.awake_a = awake_reg;
    assign res.fwd_b   = fwd_b_reg;
    assign res.rev_b   = rev_b_reg;
    assign res.awake_b = awake_reg;

endmodule

`default_nettype wire

/* dv/dual_actuator_timed_move_tb.sv */
`timescale 1ns / 1ps

module dual_actuator_timed_move_tb;
    import dactm_pkg::*;

    localparam int TIME_BITS      = 16;
    localparam int GAP_MAX        = 17;
    localparam int QUIET_LIMIT    = 400;
    localparam int PRINT_CAP      = 40;
    localparam int TICK_CAP       = 400;
    localparam logic [TIME_BITS:0] ELAPSED_TOP = '1;

    // one command word as queued for the driver
    typedef struct {
        mode_t             mode;
        logic signed [1:0] dir_a;
        logic [15:0]       time_a;
        logic signed [1:0] dir_b;
        logic [15:0]       time_b;
        bit                drain_first;    // hold back until every reply is in
    } cmd_word_t;

    // one reply word with the pin levels after the command
    typedef struct {
        reply_t reply;
        logic   fwd_a;
        logic   rev_a;
        logic   awake_a;
        logic   fwd_b;
        logic   rev_b;
        logic   awake_b;
    } pin_word_t;

    logic        clk;
    logic        rst_n       = 1'b0;
    logic        cfg_wr_en   = 1'b0;
    logic [15:0] cfg_wr_data = '0;

    // testbench-side copies of the channel inputs, known from time zero
    logic              cmd_valid  = 1'b0;
    logic [1:0]        cmd_mode   = '0;
    logic signed [1:0] cmd_dir_a  = '0;
    logic [15:0]       cmd_time_a = '0;
    logic signed [1:0] cmd_dir_b  = '0;
    logic [15:0]       cmd_time_b = '0;
    logic              res_ready  = 1'b0;

    dactm_cmd_if cmd_ch ();
    dactm_res_if res_ch ();

    assign cmd_ch.valid  = cmd_valid;
    assign cmd_ch.mode   = cmd_mode;
    assign cmd_ch.dir_a  = cmd_dir_a;
    assign cmd_ch.time_a = cmd_time_a;
    assign cmd_ch.dir_b  = cmd_dir_b;
    assign cmd_ch.time_b = cmd_time_b;
    assign res_ch.ready  = res_ready;

    dual_actuator_timed_move #(
        .TIME_BITS (TIME_BITS)
    ) dut (
        .clk         (clk),
        .rst_n       (rst_n),
        .cfg_wr_en   (cfg_wr_en),
        .cfg_wr_data (cfg_wr_data),
        .cmd         (cmd_ch),
        .res         (res_ch)
    );

    initial
    begin
        clk = 1'b0;
        forever #6 clk = ~clk;
    end

    // ------------------------------------------------------------------
    // shadow of the actuator controller, starting from its reset state
    // ------------------------------------------------------------------
    logic [15:0]          sh_timeout = TIMEOUT_RESET;
    bit                   sh_armed   = 1'b0;
    bit                   sh_moving  = 1'b0;
    logic [TIME_BITS:0]   sh_elapsed = '0;
    logic [1:0]           sh_dir   [2] = '{2'd0, 2'd0};
    logic [TIME_BITS-1:0] sh_dur   [2] = '{'0, '0};
    logic                 sh_fwd   [2] = '{1'b0, 1'b0};
    logic                 sh_rev   [2] = '{1'b0, 1'b0};
    logic                 sh_awake [2] = '{1'b0, 1'b0};

    cmd_word_t cmd_backlog [$];     // words waiting for the driver
    pin_word_t pin_expect  [$];     // replies owed by the block, oldest first

    int  errors     = 0;
    int  words_seen = 0;
    int  queued     = 0;
    bit  idle_on    = 1'b1;

    // advance the shadow by one accepted command word and give the reply it owes
    task automatic predict_bridge(input cmd_word_t c, output pin_word_t w);
        reply_t r;
        bit     unfinished;
        r = REPLY_NONE;
        case (c.mode)
            MODE_PREPARE:
            begin
                // also replaces the durations of a running move, pins untouched
                sh_dir[0] = c.dir_a;
                sh_dur[0] = c.time_a;
                sh_dir[1] = c.dir_b;
                sh_dur[1] = c.time_b;
                sh_armed  = 1'b1;
                r = REPLY_PREPARED;
            end
            MODE_START:
            begin
                // not armed: ignored altogether
                if (sh_armed)
                begin
                    for (int ch = 0; ch < 2; ch++)
                    begin
                        sh_awake[ch] = 1'b1;
                        // pattern 01 extends, any negative pattern retracts
                        sh_fwd[ch] = (sh_dir[ch] == 2'b01);
                        sh_rev[ch] = sh_dir[ch][1];
                    end
                    if (sh_dur[0] == '0 && sh_dur[1] == '0)
                    begin
                        // instant finish: pins stay set, drivers back to sleep,
                        // still armed, moving flag untouched
                        sh_awake[0] = 1'b0;
                        sh_awake[1] = 1'b0;
                        r = REPLY_DONE;
                    end
                    else
                    begin
                        sh_elapsed = '0;
                        sh_moving  = 1'b1;
                        r = REPLY_MOVING;
                    end
                end
            end
            MODE_STOP:
            begin
                for (int ch = 0; ch < 2; ch++)
                begin
                    sh_fwd[ch]   = 1'b0;
                    sh_rev[ch]   = 1'b0;
                    sh_awake[ch] = 1'b0;
                end
                sh_moving = 1'b0;
                sh_armed  = 1'b0;
                r = REPLY_STOPPED;
            end
            default:
            begin
                // tick: only counts while a move runs
                if (sh_moving)
                begin
                    if (sh_elapsed != ELAPSED_TOP)
                        sh_elapsed = sh_elapsed + 1'b1;
                    unfinished = 1'b0;
                    for (int ch = 0; ch < 2; ch++)
                    begin
                        // untimed channels keep their pins; the end of the move does not clear them
                        if (sh_dur[ch] != '0)
                        begin
                            if (sh_elapsed >= sh_dur[ch])
                            begin
                                sh_fwd[ch] = 1'b0;
                                sh_rev[ch] = 1'b0;
                            end
                            else
                                unfinished = 1'b1;
                        end
                    end
                    if (!unfinished || sh_elapsed > sh_timeout)
                    begin
                        sh_moving   = 1'b0;
                        sh_armed    = 1'b0;
                        sh_awake[0] = 1'b0;
                        sh_awake[1] = 1'b0;
                        r = REPLY_DONE;
                    end
                end
            end
        endcase
        w.reply   = r;
        w.fwd_a   = sh_fwd[0];
        w.rev_a   = sh_rev[0];
        w.awake_a = sh_awake[0];
        w.fwd_b   = sh_fwd[1];
        w.rev_b   = sh_rev[1];
        w.awake_b = sh_awake[1];
    endtask

    task automatic report_mismatch(input string what);
        errors++;
        if (errors <= PRINT_CAP)
            $display("mismatch at %0t ns: %s", $realtime, what);
    endtask

    task automatic compare_field(input string name, input logic [2:0] got,
                                 input logic [2:0] want);
        if (got !== want)
            report_mismatch($sformatf("reply word %0d field %s: got %0d, expected %0d",
                                      words_seen, name, got, want));
    endtask

    // ------------------------------------------------------------------
    // driver: presents one queued word at a time, random gap between words
    // ------------------------------------------------------------------
    cmd_word_t cur_word = '{MODE_TICK, 2'sd0, 16'd0, 2'sd0, 16'd0, 1'b0};
    bit        holding  = 1'b0;
    int        gap_left = 0;

    always @(posedge clk)
    begin : drive_words
        pin_word_t w;
        if (rst_n)
        begin
            // holding mirrors cmd_valid, so this is the accepting edge
            if (holding && cmd_ch.ready)
            begin
                predict_bridge(cur_word, w);
                pin_expect.push_back(w);
                holding  = 1'b0;
                gap_left = idle_on ? $urandom_range(0, GAP_MAX) : 0;
            end
            if (!holding)
            begin
                if (gap_left > 0)
                    gap_left--;
                else if (cmd_backlog.size() > 0 &&
                         !(cmd_backlog[0].drain_first && pin_expect.size() > 0))
                begin
                    cur_word = cmd_backlog.pop_front();
                    holding  = 1'b1;
                end
            end
            cmd_valid  <= holding;
            cmd_mode   <= cur_word.mode;
            cmd_dir_a  <= cur_word.dir_a;
            cmd_time_a <= cur_word.time_a;
            cmd_dir_b  <= cur_word.dir_b;
            cmd_time_b <= cur_word.time_b;
        end
    end

    // ------------------------------------------------------------------
    // monitor: takes reply words, stalls at random after each one
    // ------------------------------------------------------------------
    int stall_left = 0;

    always @(posedge clk)
    begin : take_replies
        pin_word_t want;
        if (rst_n)
        begin
            if (res_ready && res_ch.valid)
            begin
                words_seen++;
                if (pin_expect.size() == 0)
                    report_mismatch($sformatf("reply word %0d arrived with none owed",
                                              words_seen));
                else
                begin
                    want = pin_expect.pop_front();
                    compare_field("reply",   res_ch.reply,   want.reply);
                    compare_field("fwd_a",   res_ch.fwd_a,   want.fwd_a);
                    compare_field("rev_a",   res_ch.rev_a,   want.rev_a);
                    compare_field("awake_a", res_ch.awake_a, want.awake_a);
                    compare_field("fwd_b",   res_ch.fwd_b,   want.fwd_b);
                    compare_field("rev_b",   res_ch.rev_b,   want.rev_b);
                    compare_field("awake_b", res_ch.awake_b, want.awake_b);
                end
                stall_left = idle_on ? $urandom_range(0, GAP_MAX) : 0;
            end
            if (stall_left > 0)
            begin
                stall_left--;
                res_ready <= 1'b0;
            end
            else
                res_ready <= 1'b1;
        end
    end

    // watchdog: too long with no word moving on either side means a hang
    int quiet_cycles = 0;

    always @(posedge clk)
    begin
        if (rst_n)
        begin
            if ((cmd_valid && cmd_ch.ready) || (res_ready && res_ch.valid))
                quiet_cycles = 0;
            else
                quiet_cycles++;
            if (quiet_cycles >= QUIET_LIMIT)
            begin
                $display("dual_actuator_timed_move verification failed");
                $finish;
            end
        end
    end

    // ------------------------------------------------------------------
    // stimulus
    // ------------------------------------------------------------------
    task automatic push_word(input mode_t m, input logic [1:0] da, input logic [15:0] ta,
                             input logic [1:0] db, input logic [15:0] tb,
                             input bit drain = 1'b0);
        cmd_word_t c;
        c.mode        = m;
        c.dir_a       = da;
        c.time_a      = ta;
        c.dir_b       = db;
        c.time_b      = tb;
        c.drain_first = drain;
        cmd_backlog.push_back(c);
        queued++;
    endtask

    // a tick, start or stop word with junk in the unused fields
    task automatic push_bare(input mode_t m);
        push_word(m, 2'($urandom_range(0, 3)), 16'($urandom()),
                  2'($urandom_range(0, 3)), 16'($urandom()), $urandom_range(0, 39) == 0);
    endtask

    // mostly short durations, some untimed, now and then anything at all
    function automatic logic [15:0] pick_duration(input int cap);
        int sel;
        sel = $urandom_range(0, 9);
        if (sel < 3)
            return 16'd0;
        else if (sel == 3)
            return 16'($urandom());
        else
            return 16'($urandom_range(1, cap));
    endfunction

    // block idle: nothing queued, nothing on the channel, no reply owed
    task automatic wait_idle();
        while (cmd_backlog.size() != 0 || holding || pin_expect.size() != 0)
            @(posedge clk);
        repeat (3) @(posedge clk);
    endtask

    task automatic set_timeout(input logic [15:0] v);
        wait_idle();
        cfg_wr_en   <= 1'b1;
        cfg_wr_data <= v;
        @(posedge clk);
        cfg_wr_en   <= 1'b0;
        sh_timeout = v;
        @(posedge clk);
    endtask

    // mostly prepare, start and enough ticks to finish; the rest is noise,
    // cut-short moves, restarts and re-prepares in the middle of a move
    task automatic run_moves(input int n_words, input int cap);
        int          target;
        int          span;
        int          variant;
        int          cut;
        logic [15:0] ta;
        logic [15:0] tb;
        target = queued + n_words;
        while (queued < target)
        begin
            if ($urandom_range(0, 99) < 78)
            begin
                ta = pick_duration(cap);
                tb = pick_duration(cap);
                push_word(MODE_PREPARE, 2'($urandom_range(0, 3)), ta,
                          2'($urandom_range(0, 3)), tb, $urandom_range(0, 39) == 0);
                push_bare(MODE_START);
                span = (ta > tb) ? int'(ta) : int'(tb);
                if (span > int'(sh_timeout))
                    span = int'(sh_timeout) + 1;
                if (span > TICK_CAP)
                    span = TICK_CAP;
                variant = $urandom_range(0, 9);
                cut = $urandom_range(0, span);
                for (int i = 0; i < span; i++)
                begin
                    if (i == cut && variant == 0)
                        break;
                    if (i == cut && variant == 1)
                        push_word(MODE_PREPARE, 2'($urandom_range(0, 3)), pick_duration(cap),
                                  2'($urandom_range(0, 3)), pick_duration(cap));
                    if (i == cut && variant == 2)
                        push_bare(MODE_START);
                    push_bare(MODE_TICK);
                end
                if (variant == 0)
                    push_bare(MODE_STOP);
                if (variant == 3)
                    repeat ($urandom_range(1, 3)) push_bare(MODE_TICK);
            end
            else
                push_word(mode_t'($urandom_range(0, 3)), 2'($urandom_range(0, 3)),
                          16'($urandom()), 2'($urandom_range(0, 3)), 16'($urandom()));
        end
    endtask

    initial
    begin : stimulus
        repeat (12) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // directed words under the reset timeout
        push_word(MODE_TICK, 2'b00, 16'd0, 2'b00, 16'd0);        // tick while idle
        push_word(MODE_START, 2'b01, 16'hffff, 2'b11, 16'hffff); // start while disarmed
        push_word(MODE_STOP, 2'b00, 16'd0, 2'b00, 16'd0);
        push_word(MODE_PREPARE, 2'b01, 16'd3, 2'b11, 16'd5);
        push_word(MODE_START, 2'b00, 16'd0, 2'b00, 16'd0);
        repeat (5) push_word(MODE_TICK, 2'b00, 16'd0, 2'b00, 16'd0);
        // direction minus two, both untimed: instant finish, twice while armed
        push_word(MODE_PREPARE, 2'b10, 16'd0, 2'b00, 16'd0);
        push_word(MODE_START, 2'b00, 16'd0, 2'b00, 16'd0);
        push_word(MODE_START, 2'b00, 16'd0, 2'b00, 16'd0);
        // untimed channel next to a timed one, re-prepared mid-move
        push_word(MODE_PREPARE, 2'b01, 16'd0, 2'b10, 16'd4);
        push_word(MODE_START, 2'b00, 16'd0, 2'b00, 16'd0);
        repeat (2) push_word(MODE_TICK, 2'b00, 16'd0, 2'b00, 16'd0);
        push_word(MODE_PREPARE, 2'b11, 16'd1, 2'b01, 16'd1);
        push_word(MODE_TICK, 2'b00, 16'd0, 2'b00, 16'd0);
        // longest durations, restart during a move, then stop
        push_word(MODE_PREPARE, 2'b01, 16'hffff, 2'b01, 16'hffff, 1'b1);
        push_word(MODE_START, 2'b00, 16'd0, 2'b00, 16'd0);
        push_word(MODE_TICK, 2'b00, 16'd0, 2'b00, 16'd0);
        push_word(MODE_START, 2'b00, 16'd0, 2'b00, 16'd0);
        push_word(MODE_TICK, 2'b00, 16'd0, 2'b00, 16'd0);
        push_word(MODE_STOP, 2'b00, 16'd0, 2'b00, 16'd0);
        push_word(MODE_TICK, 2'b00, 16'd0, 2'b00, 16'd0);

        // one move that only the timeout ends, at full rate
        set_timeout(16'd40);
        idle_on = 1'b0;
        push_word(MODE_PREPARE, 2'b01, 16'd0, 2'b11, 16'd30000);
        push_word(MODE_START, 2'b00, 16'd0, 2'b00, 16'd0);
        repeat (41) push_word(MODE_TICK, 2'b00, 16'd0, 2'b00, 16'd0);

        // zero timeout: any timed move ends on its first tick
        set_timeout(16'd0);
        idle_on = 1'b1;
        push_word(MODE_PREPARE, 2'b01, 16'hffff, 2'b10, 16'd0);
        push_word(MODE_START, 2'b00, 16'd0, 2'b00, 16'd0);
        push_word(MODE_TICK, 2'b00, 16'd0, 2'b00, 16'd0);
        run_moves(250, 20);

        // largest timeout, moves end by their durations
        set_timeout(16'hffff);
        run_moves(450, 25);

        // short timeout, long durations, no idling
        set_timeout(16'($urandom_range(1, 30)));
        idle_on = 1'b0;
        run_moves(350, 60);

        set_timeout(16'($urandom()));
        idle_on = 1'b1;
        run_moves(400, 30);

        set_timeout(TIMEOUT_RESET);
        run_moves(350, 20);

        // drain, then give the block a few more cycles
        wait_idle();
        repeat (8) @(posedge clk);
        if (pin_expect.size() != 0)
            report_mismatch($sformatf("%0d reply words never arrived", pin_expect.size()));
        if (errors == 0)
            $display("dual_actuator_timed_move verification clean");
        else
            $display("dual_actuator_timed_move verification failed");
        $finish;
    end

endmodule

/* files.f */
rtl/dactm_pkg.sv
rtl/dactm_if.sv
rtl/dactm_chan.sv
rtl/dual_actuator_timed_move.sv
dv/dual_actuator_timed_move_tb.sv
